// ===== rtl/jgsc_pkg.sv =====
// ----------------------------------------------------------------------------
// jgsc_pkg: shared types, codes and grammar table
// Word formats, grammar symbol codes, token, event and error codes, and the
// per-token rule decode used by the grammar stack checker.
// ----------------------------------------------------------------------------
package jgsc_pkg;

	localparam int STACK_DEPTH_DEF = 64;

	// register window on top of the symbol stack
	localparam int WIN_DEPTH   = 16;
	localparam int WIN_AW      = $clog2(WIN_DEPTH);
	localparam int WIN_CW      = $clog2(WIN_DEPTH + 1);
	localparam int SPILL_LEVEL = 8;
	localparam int FILL_LEVEL  = 3;

	// grammar symbols
	localparam logic [2:0] SYM_VALUE     = 3'd0;
	localparam logic [2:0] SYM_ARR_FIRST = 3'd1;
	localparam logic [2:0] SYM_ARR_REST  = 3'd2;
	localparam logic [2:0] SYM_OBJ_FIRST = 3'd3;
	localparam logic [2:0] SYM_OBJ_REST  = 3'd4;
	localparam logic [2:0] SYM_KEY       = 3'd5;
	localparam logic [2:0] SYM_COLON     = 3'd6;
	localparam logic [2:0] SYM_COMMA     = 3'd7;

	// commands
	localparam logic CMD_TOKEN = 1'b0;
	localparam logic CMD_EOF   = 1'b1;

	// tokens
	localparam logic [3:0] TOK_REAL      = 4'd0;
	localparam logic [3:0] TOK_LITERAL   = 4'd3;
	localparam logic [3:0] TOK_STRING    = 4'd2;
	localparam logic [3:0] TOK_BEGIN_ARR = 4'd4;
	localparam logic [3:0] TOK_END_ARR   = 4'd5;
	localparam logic [3:0] TOK_BEGIN_OBJ = 4'd6;
	localparam logic [3:0] TOK_END_OBJ   = 4'd7;
	localparam logic [3:0] TOK_COMMA     = 4'd8;
	localparam logic [3:0] TOK_COLON     = 4'd9;

	// events
	localparam logic [3:0] EV_NONE       = 4'd0;
	localparam logic [3:0] EV_BEGIN_ARR  = 4'd5;
	localparam logic [3:0] EV_END_ARR    = 4'd6;
	localparam logic [3:0] EV_BEGIN_OBJ  = 4'd7;
	localparam logic [3:0] EV_END_OBJ    = 4'd8;
	localparam logic [3:0] EV_KEY        = 4'd9;
	localparam logic [3:0] EV_EOF        = 4'd10;
	localparam logic [3:0] EV_ERROR      = 4'd11;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_EMPTY     = 3'd1;
	localparam logic [2:0] ERR_NOT_VALUE = 3'd2;
	localparam logic [2:0] ERR_ARRAY     = 3'd3;
	localparam logic [2:0] ERR_OBJECT    = 3'd4;
	localparam logic [2:0] ERR_COMMA     = 3'd5;
	localparam logic [2:0] ERR_EOF       = 3'd6;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd7;

	typedef struct packed {
		logic       command;
		logic [3:0] token;
	} cmd_word_t;

	typedef struct packed {
		logic [3:0] event_res;
		logic [2:0] error_code;
	} evt_word_t;

	// one grammar step: push list is top first
	typedef struct packed {
		logic [2:0]      err;
		logic [3:0]      ev;
		logic [2:0]      n_push;
		logic [3:0][2:0] push;
	} step_t;

	function automatic step_t decode_step(input logic [2:0] sym, input logic [3:0] tok);
		step_t s;
		logic  scalar;
		s      = '0;
		scalar = (tok inside {[TOK_REAL:TOK_LITERAL]});
		case (sym)
			SYM_VALUE: begin
				if (scalar) begin
					s.ev = tok + 4'd1;
				end else if (tok == TOK_BEGIN_ARR) begin
					s.n_push  = 3'd1;
					s.push[0] = SYM_ARR_FIRST;
					s.ev      = EV_BEGIN_ARR;
				end else if (tok == TOK_BEGIN_OBJ) begin
					s.n_push  = 3'd1;
					s.push[0] = SYM_OBJ_FIRST;
					s.ev      = EV_BEGIN_OBJ;
				end else begin
					s.err = ERR_NOT_VALUE;
				end
			end
			SYM_ARR_FIRST: begin
				if (tok == TOK_END_ARR) begin
					s.ev = EV_END_ARR;
				end else if (scalar) begin
					s.n_push  = 3'd1;
					s.push[0] = SYM_ARR_REST;
					s.ev      = tok + 4'd1;
				end else if (tok == TOK_BEGIN_ARR) begin
					s.n_push  = 3'd2;
					s.push[0] = SYM_ARR_FIRST;
					s.push[1] = SYM_ARR_REST;
					s.ev      = EV_BEGIN_ARR;
				end else if (tok == TOK_BEGIN_OBJ) begin
					s.n_push  = 3'd2;
					s.push[0] = SYM_OBJ_FIRST;
					s.push[1] = SYM_ARR_REST;
					s.ev      = EV_BEGIN_OBJ;
				end else begin
					s.err = ERR_ARRAY;
				end
			end
			SYM_ARR_REST: begin
				if (tok == TOK_END_ARR) begin
					s.ev = EV_END_ARR;
				end else if (tok == TOK_COMMA) begin
					s.n_push  = 3'd2;
					s.push[0] = SYM_VALUE;
					s.push[1] = SYM_ARR_REST;
					s.ev      = EV_NONE;
				end else begin
					s.err = ERR_ARRAY;
				end
			end
			SYM_OBJ_FIRST: begin
				if (tok == TOK_END_OBJ) begin
					s.ev = EV_END_OBJ;
				end else if (tok == TOK_STRING) begin
					s.n_push  = 3'd3;
					s.push[0] = SYM_COLON;
					s.push[1] = SYM_VALUE;
					s.push[2] = SYM_OBJ_REST;
					s.ev      = EV_KEY;
				end else begin
					s.err = ERR_OBJECT;
				end
			end
			SYM_OBJ_REST: begin
				if (tok == TOK_END_OBJ) begin
					s.ev = EV_END_OBJ;
				end else if (tok == TOK_COMMA) begin
					s.n_push  = 3'd4;
					s.push[0] = SYM_KEY;
					s.push[1] = SYM_COLON;
					s.push[2] = SYM_VALUE;
					s.push[3] = SYM_OBJ_REST;
					s.ev      = EV_NONE;
				end else begin
					s.err = ERR_OBJECT;
				end
			end
			SYM_KEY: begin
				if (tok == TOK_STRING) begin
					s.ev = EV_KEY;
				end else begin
					s.err = ERR_OBJECT;
				end
			end
			SYM_COLON: begin
				if (tok == TOK_COLON) begin
					s.ev = EV_NONE;
				end else begin
					s.err = ERR_OBJECT;
				end
			end
			default: begin
				// comma symbol
				if (tok == TOK_COMMA) begin
					s.ev = EV_NONE;
				end else begin
					s.err = ERR_COMMA;
				end
			end
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/jgsc_ram.sv =====
// ----------------------------------------------------------------------------
// jgsc_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module jgsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/json_grammar_stack_checker.sv =====
// ----------------------------------------------------------------------------
// json_grammar_stack_checker: json grammar check with a pushdown symbol stack
// Takes json token codes, checks them against the json grammar and turns each
// one into a pull event or a grammar error.
// ----------------------------------------------------------------------------
//
//   channel   | dir | word         | fields
//   ----------+-----+--------------+-----------------------------------
//   cmd       | in  | cmd_word_t   | command, token
//   evt       | out | evt_word_t   | event_res, error_code
//
// one word per cycle while evt_ready keeps up; each result is registered (output or skid slot)
// the stack top always sits in a 16-entry register window; deeper entries
//   move to and from the stack ram one per cycle in the background
// reset: state held in flops, the ram needs no clearing pass
// an output register plus a skid slot: cmd is taken while a result waits,
//   and cmd_ready drops only when both slots are full
//
module json_grammar_stack_checker #(
	parameter int STACK_DEPTH = jgsc_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  jgsc_pkg::cmd_word_t cmd_word,
	output logic                evt_valid,
	input  logic                evt_ready,
	output jgsc_pkg::evt_word_t evt_word
);

	import jgsc_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// run status codes
	localparam logic [1:0] ST_RUN     = 2'd0;
	localparam logic [1:0] ST_EOF     = 2'd1;
	localparam logic [1:0] ST_ERR_EOF = 2'd2;
	localparam logic [1:0] ST_ERR_OVF = 2'd3;

	// state
	logic [1:0]        run_q;
	logic [CW-1:0]     count_q;      // total stack depth
	logic [CW-1:0]     ram_cnt_q;    // entries held in the ram
	logic [WIN_CW-1:0] wcnt_q;       // entries held in the window
	logic              fill_pend_q;  // ram read in flight
	logic [2:0]        win_q [WIN_DEPTH];

	// output side
	evt_word_t out_q;
	logic      out_valid_q;
	evt_word_t skid_q;
	logic      skid_valid_q;

	// step signals
	logic              accept;
	step_t             dec;
	evt_word_t         res;
	logic [1:0]        run_d;
	logic              act_pop;
	logic [2:0]        act_n;
	logic [CW:0]       depth_after;
	logic [WIN_CW-1:0] wcnt_step;
	logic [WIN_CW-1:0] spill_pos;
	logic [2:0]        win_d [WIN_DEPTH];

	// spill and fill
	logic              spill;
	logic              fill_go;
	logic [2:0]        ram_rd_data;

	assign accept    = cmd_valid && cmd_ready;
	assign cmd_ready = !skid_valid_q;

	// rule lookup on the window top
	assign dec = decode_step(win_q[0], cmd_word.token);

	// depth the stack would reach after pop and pushes
	assign depth_after = {1'b0, count_q} - (CW+1)'(1) + (CW+1)'(dec.n_push);

	always_comb begin
		res     = '{event_res: EV_NONE, error_code: ERR_NONE};
		run_d   = run_q;
		act_pop = 1'b0;
		act_n   = 3'd0;
		case (run_q)
			ST_EOF: begin
				res.event_res = EV_EOF;
			end
			ST_ERR_EOF: begin
				res = '{event_res: EV_ERROR, error_code: ERR_EOF};
			end
			ST_ERR_OVF: begin
				res = '{event_res: EV_ERROR, error_code: ERR_OVERFLOW};
			end
			default: begin
				if (cmd_word.command == CMD_EOF) begin
					// only an empty stack or a lone value symbol may end
					if (count_q == '0 || (count_q == CW'(1) && win_q[0] == SYM_VALUE)) begin
						res.event_res = EV_EOF;
						run_d         = ST_EOF;
					end else begin
						res   = '{event_res: EV_ERROR, error_code: ERR_EOF};
						run_d = ST_ERR_EOF;
					end
				end else if (count_q == '0) begin
					res = '{event_res: EV_ERROR, error_code: ERR_EMPTY};
				end else if (dec.err != ERR_NONE) begin
					// symbol stays consumed
					act_pop = 1'b1;
					res     = '{event_res: EV_ERROR, error_code: dec.err};
				end else if (depth_after > (CW+1)'(STACK_DEPTH)) begin
					// stack left untouched
					res   = '{event_res: EV_ERROR, error_code: ERR_OVERFLOW};
					run_d = ST_ERR_OVF;
				end else begin
					act_pop       = 1'b1;
					act_n         = dec.n_push;
					res.event_res = dec.ev;
				end
			end
		endcase
	end

	// background traffic between window bottom and ram; never both at once
	assign spill     = !fill_pend_q && (wcnt_q >= WIN_CW'(SPILL_LEVEL));
	assign fill_go   = !spill && (ram_cnt_q != '0)
		&& ((wcnt_q + WIN_CW'(fill_pend_q)) <= WIN_CW'(FILL_LEVEL));
	assign spill_pos = wcnt_q - WIN_CW'(1);

	// window count after this word's pop and pushes
	assign wcnt_step = wcnt_q + WIN_CW'(accept ? act_n : 3'd0)
		- WIN_CW'(accept && act_pop);

	// window shift: pushes enter at the top, the rest move by pushes minus one
	always_comb begin
		int src;
		src = 0;
		for (int j = 0; j < WIN_DEPTH; j++) begin
			win_d[j] = win_q[j];
		end
		if (accept && act_pop) begin
			for (int j = 0; j < WIN_DEPTH; j++) begin
				src = j + 1 - int'(act_n);
				if (j < int'(act_n)) begin
					win_d[j] = dec.push[j[1:0]];
				end else if (src < WIN_DEPTH) begin
					win_d[j] = win_q[src[WIN_AW-1:0]];
				end
			end
		end
		// fill data lands just below the current bottom
		if (fill_pend_q) begin
			win_d[wcnt_step[WIN_AW-1:0]] = ram_rd_data;
		end
	end

	jgsc_ram #(
		.WIDTH (3),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (spill),
		.wr_addr (ram_cnt_q[AW-1:0]),
		.wr_data (win_q[spill_pos[WIN_AW-1:0]]),
		.rd_en   (fill_go),
		.rd_addr (AW'(ram_cnt_q - CW'(1))),
		.rd_data (ram_rd_data)
	);

	// stack and status registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= ST_RUN;
			count_q     <= CW'(1);
			ram_cnt_q   <= '0;
			wcnt_q      <= WIN_CW'(1);
			fill_pend_q <= 1'b0;
			for (int j = 0; j < WIN_DEPTH; j++) begin
				win_q[j] <= SYM_VALUE;
			end
		end else begin
			if (accept) begin
				run_q   <= run_d;
				count_q <= count_q - CW'(act_pop) + CW'(act_n);
			end
			wcnt_q      <= wcnt_step + WIN_CW'(fill_pend_q) - WIN_CW'(spill);
			ram_cnt_q   <= ram_cnt_q + CW'(spill) - CW'(fill_go);
			fill_pend_q <= fill_go;
			win_q       <= win_d;
		end
	end

	// output register with skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (out_valid_q && !evt_ready) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_valid_q && evt_ready) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (out_valid_q && !evt_ready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (out_valid_q && evt_ready && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign evt_valid = out_valid_q;
	assign evt_word  = out_q;

`ifndef SYNTHESIS
	// the top symbol must be in the window whenever the stack is not empty
	a_top_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (wcnt_q != '0))
		else $error("stack top missing from window");

	// window never fills completely, so a fill always has a slot
	a_window_room: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q < WIN_CW'(WIN_DEPTH))
		else $error("symbol window overrun");

	// window, ram and read in flight together hold the whole stack
	a_depth_split: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) == int'(ram_cnt_q) + int'(wcnt_q) + int'(fill_pend_q))
		else $error("stack depth bookkeeping mismatch");

	// skid slot only fills behind a waiting output word
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot holds a word with empty output register");

	// an error code comes only with an error event
	a_code_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.event_res != EV_ERROR) |-> (out_q.error_code == ERR_NONE))
		else $error("error code without error event");
`endif

endmodule
